[hw/rtl/b64lw_pkg.sv]
// Shared types, constants and the sextet-to-character map of the base64 line-wrapping encoder.
// Depends on nothing; the front end, queue, back end and top of the block refer to it by scoped names.
package b64lw_pkg;

	typedef enum logic [1:0] {
		CMD_DATA   = 2'd0,
		CMD_EOL    = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] PAD_CHAR     = 8'h3D;
	localparam logic [7:0] WRAP_RESET   = 8'd70;

	// Characters caused by one input word, emitted in order chars[0] .. chars[last_idx].
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
	} bundle_t;

	// Standard base64 alphabet.
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return 8'(8'd65 + w);
		else if (v < 6'd52)
			return 8'(8'd71 + w);
		else if (v < 6'd62)
			return 8'(w - 8'd4);
		else if (v == 6'd62)
			return 8'h2B;
		else
			return 8'h2F;
	endfunction

endpackage

[hw/rtl/b64lw_in_if.sv]
// Input channel of the encoder: one command word with an optional raw byte.
// Depends on nothing.
interface b64lw_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;

	modport source(output valid, command, data_byte, input ready);
	modport sink(input valid, command, data_byte, output ready);
endinterface

[hw/rtl/b64lw_out_if.sv]
// Output channel of the encoder: one ASCII character per word.
// Depends on nothing.
interface b64lw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_of_run;

	modport source(output valid, out_char, last_of_run, input ready);
	modport sink(input valid, out_char, last_of_run, output ready);
endinterface

[hw/rtl/base64_line_wrapping_encoder.sv]
// Streaming base64 encoder with line wrapping; uses b64lw_pkg, both channel interfaces,
// b64lw_front, b64lw_queue and b64lw_back.
// A word's characters pass through the bundle queue and then the output register.
// Throughput: one word per cycle enters while the bundle queue has room; characters leave
// at one per cycle from the output register while the receiver is ready, so the output,
// four characters per three data bytes plus each line break, sets the pace.
// Reset: arst_n clears the encoder state, the queue and the output; wrap threshold to 70.
module base64_line_wrapping_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	b64lw_in_if.sink     item,
	b64lw_out_if.source  result,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);

	logic               queue_full;
	logic               push_valid;
	b64lw_pkg::bundle_t push_data;
	logic               head_valid;
	b64lw_pkg::bundle_t head;
	logic               pop;

	b64lw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.queue_full (queue_full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	b64lw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	b64lw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);

endmodule

[hw/rtl/b64lw_front.sv]
// Front end: accepts command words, keeps the encoder state and the wrap register,
// and turns each word into a bundle of up to four characters. Depends on b64lw_pkg.
module b64lw_front (
	input  logic                clk,
	input  logic                arst_n,
	b64lw_in_if.sink            item,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                queue_full,
	output logic                push_valid,
	output b64lw_pkg::bundle_t  push_data
);

	localparam logic [2:0] LEFT_NONE = 3'd0;
	localparam logic [2:0] LEFT_TWO  = 3'd2;
	localparam logic [2:0] LEFT_FOUR = 3'd4;

	logic [7:0] wrap_q;
	logic [3:0] lbits_q;
	logic [2:0] lcnt_q;
	logic [7:0] col_q;
	logic       atls_q;

	logic [3:0] lbits_d;
	logic [2:0] lcnt_d;
	logic [7:0] col_d;
	logic       atls_d;

	logic            accept;
	logic            enc_go;
	logic [7:0]      enc_byte;
	logic [2:0]      n_c;
	logic [3:0][7:0] ch_c;
	logic [8:0]      sum1;
	logic [8:0]      sum2;
	logic [8:0]      sum3;
	logic [7:0]      col1;
	logic [7:0]      col2;
	logic [7:0]      col3;
	logic [7:0]      col_fin;

	assign item.ready = !queue_full;
	assign accept     = item.valid && item.ready;

	assign sum1 = {1'b0, col_q} + 9'd1;
	assign sum2 = {1'b0, col_q} + 9'd2;
	assign sum3 = {1'b0, col_q} + 9'd3;
	// saturate the column at 255
	assign col1 = sum1[8] ? 8'hFF : sum1[7:0];
	assign col2 = sum2[8] ? 8'hFF : sum2[7:0];
	assign col3 = sum3[8] ? 8'hFF : sum3[7:0];

	always_comb begin
		lbits_d  = lbits_q;
		lcnt_d   = lcnt_q;
		col_d    = col_q;
		atls_d   = atls_q;
		enc_go   = 1'b0;
		enc_byte = item.data_byte;
		n_c      = 3'd0;
		ch_c     = '0;
		col_fin  = col_q;
		case (item.command)
			b64lw_pkg::CMD_DATA: begin
				enc_go = 1'b1;
			end
			b64lw_pkg::CMD_EOL: begin
				if (!atls_q) begin
					enc_go   = 1'b1;
					enc_byte = b64lw_pkg::NEWLINE_CHAR;
				end
			end
			b64lw_pkg::CMD_FINISH: begin
				case (lcnt_q)
					LEFT_FOUR: begin
						ch_c[0] = b64lw_pkg::sextet_char({lbits_q, 2'b00});
						ch_c[1] = b64lw_pkg::PAD_CHAR;
						n_c     = 3'd2;
						col_fin = col2;
					end
					LEFT_TWO: begin
						ch_c[0] = b64lw_pkg::sextet_char({lbits_q[1:0], 4'b0000});
						ch_c[1] = b64lw_pkg::PAD_CHAR;
						ch_c[2] = b64lw_pkg::PAD_CHAR;
						n_c     = 3'd3;
						col_fin = col3;
					end
					default: begin
						col_fin = col_q;
					end
				endcase
				if (col_fin != 8'd0) begin
					ch_c[n_c[1:0]] = b64lw_pkg::NEWLINE_CHAR;
					n_c            = 3'(n_c + 3'd1);
				end
				lbits_d = 4'd0;
				lcnt_d  = LEFT_NONE;
				col_d   = 8'd0;
				atls_d  = 1'b1;
			end
			default: begin
				enc_go = 1'b0;
			end
		endcase

		if (enc_go) begin
			case (lcnt_q)
				LEFT_TWO: begin
					ch_c[0] = b64lw_pkg::sextet_char({lbits_q[1:0], enc_byte[7:4]});
					n_c     = 3'd1;
					col_d   = col1;
					lbits_d = enc_byte[3:0];
					lcnt_d  = LEFT_FOUR;
				end
				LEFT_FOUR: begin
					// group completes: two characters, then a line break past the threshold
					ch_c[0] = b64lw_pkg::sextet_char({lbits_q, enc_byte[7:6]});
					ch_c[1] = b64lw_pkg::sextet_char(enc_byte[5:0]);
					lbits_d = 4'd0;
					lcnt_d  = LEFT_NONE;
					if (col2 > wrap_q) begin
						ch_c[2] = b64lw_pkg::NEWLINE_CHAR;
						n_c     = 3'd3;
						col_d   = 8'd0;
					end else begin
						n_c   = 3'd2;
						col_d = col2;
					end
				end
				default: begin
					ch_c[0] = b64lw_pkg::sextet_char(enc_byte[7:2]);
					n_c     = 3'd1;
					col_d   = col1;
					lbits_d = {2'b00, enc_byte[1:0]};
					lcnt_d  = LEFT_TWO;
				end
			endcase
			atls_d = (enc_byte == b64lw_pkg::NEWLINE_CHAR);
		end
	end

	assign push_valid         = accept && (n_c != 3'd0);
	assign push_data.chars    = ch_c;
	assign push_data.last_idx = 2'(n_c - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= b64lw_pkg::WRAP_RESET;
		end else if (cfg_we) begin
			wrap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbits_q <= 4'd0;
			lcnt_q  <= LEFT_NONE;
			col_q   <= 8'd0;
			atls_q  <= 1'b1;
		end else if (accept) begin
			lbits_q <= lbits_d;
			lcnt_q  <= lcnt_d;
			col_q   <= col_d;
			atls_q  <= atls_d;
		end
	end

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.command == b64lw_pkg::CMD_FINISH) |=>
		(lcnt_q == LEFT_NONE && col_q == 8'd0 && atls_q && lbits_q == 4'd0))
		else $error("finish did not return the state to reset");

	a_left_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(lcnt_q == LEFT_NONE || lcnt_q == LEFT_TWO || lcnt_q == LEFT_FOUR))
		else $error("leftover count left the set 0, 2, 4");

endmodule

[hw/rtl/b64lw_queue.sv]
// Short queue of character bundles between the front end and the back end.
// Depends on b64lw_pkg.
module b64lw_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  b64lw_pkg::bundle_t  push_data,
	output logic                full,
	output logic                head_valid,
	output b64lw_pkg::bundle_t  head,
	input  logic                pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	b64lw_pkg::bundle_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push_valid && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push_valid) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !full)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

[hw/rtl/b64lw_back.sv]
// Back end: walks the head bundle one character per cycle into the output register
// while the output register is empty or being taken. Depends on b64lw_pkg.
module b64lw_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  b64lw_pkg::bundle_t  head,
	output logic                pop,
	b64lw_out_if.source         result
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load   = head_valid && (!valid_q || result.ready);
	assign at_end = (idx_q == head.last_idx);
	// drop the bundle once its last character moves into the output register
	assign pop    = load && at_end;

	assign result.valid       = valid_q;
	assign result.out_char    = char_q;
	assign result.last_of_run = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head.chars[idx_q];
			last_q <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= at_end ? 2'd0 : 2'(idx_q + 2'd1);
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q <= head.last_idx))
		else $error("character index past the end of the bundle");

	a_idx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (idx_q == 2'd0))
		else $error("character index not rewound with the queue empty");

endmodule

[bench/b64lw_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard class for the base64 line-wrapping encoder bench: predicts the characters
// of each accepted word and checks every character that leaves the block.
// Depends on b64lw_pkg for the command codes and the newline, pad and reset constants.
package b64lw_tb_pkg;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Index 0 is the leftmost character of the literal.
	localparam logic [0:63][7:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	class b64_char_checker;
		logic [7:0] wrap_at;
		logic [3:0] spare_bits;
		int         spare_count;
		int         column;
		bit         line_start;
		enc_char_t  expected_chars[$];
		enc_char_t  run_chars[$];
		int         errors;
		int         words_noted;
		int         chars_checked;
		int         newlines_seen;
		int         pads_seen;

		function new();
			wrap_at = b64lw_pkg::WRAP_RESET;
			errors = 0;
			words_noted = 0;
			chars_checked = 0;
			newlines_seen = 0;
			pads_seen = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			spare_bits = '0;
			spare_count = 0;
			column = 0;
			line_start = 1'b1;
		endfunction

		function void set_wrap(logic [7:0] v);
			wrap_at = v;
		endfunction

		function void emit(logic [7:0] c);
			enc_char_t e;
			e.ch = c;
			e.last = 1'b0;
			run_chars.push_back(e);
		endfunction

		function void bump(int by);
			column += by;
			if (column > 255)
				column = 255;
		endfunction

		function void encode_byte(logic [7:0] c);
			logic [11:0] acc;
			logic [5:0]  sx;
			int          cnt;
			// spare_bits holds only valid bits, zero above spare_count
			acc = {spare_bits, c};
			cnt = spare_count + 8;
			do begin
				cnt -= 6;
				sx = 6'(acc >> cnt);
				emit(ALPHABET[sx]);
				bump(1);
				if (cnt == 0 && column > int'(wrap_at)) begin
					emit(b64lw_pkg::NEWLINE_CHAR);
					column = 0;
				end
			end while (cnt >= 6);
			spare_count = cnt;
			spare_bits = 4'(acc & ((12'd1 << cnt) - 12'd1));
			line_start = (c == b64lw_pkg::NEWLINE_CHAR);
		endfunction

		// Predict the characters of one accepted word and queue them.
		function void note_word(logic [1:0] cmd, logic [7:0] b);
			enc_char_t e;
			run_chars.delete();
			words_noted++;
			case (cmd)
				b64lw_pkg::CMD_DATA: encode_byte(b);
				b64lw_pkg::CMD_EOL: if (!line_start) encode_byte(b64lw_pkg::NEWLINE_CHAR);
				b64lw_pkg::CMD_FINISH: begin
					if (spare_count == 4) begin
						emit(ALPHABET[{spare_bits, 2'b00}]);
						emit(b64lw_pkg::PAD_CHAR);
						bump(2);
					end else if (spare_count == 2) begin
						emit(ALPHABET[{spare_bits[1:0], 4'b0000}]);
						emit(b64lw_pkg::PAD_CHAR);
						emit(b64lw_pkg::PAD_CHAR);
						bump(3);
					end
					if (column != 0)
						emit(b64lw_pkg::NEWLINE_CHAR);
					clear_stream();
				end
				default: ;
			endcase
			if (run_chars.size() > 0) begin
				e = run_chars.pop_back();
				e.last = 1'b1;
				run_chars.push_back(e);
			end
			foreach (run_chars[i])
				expected_chars.push_back(run_chars[i]);
		endfunction

		function void check_char(logic [7:0] ch, logic last);
			enc_char_t e;
			chars_checked++;
			if (ch == b64lw_pkg::NEWLINE_CHAR)
				newlines_seen++;
			if (ch == b64lw_pkg::PAD_CHAR)
				pads_seen++;
			if (expected_chars.size() == 0) begin
				errors++;
				$display("%0t: no character expected, got out_char %h last_of_run %b",
					$time, ch, last);
				return;
			end
			e = expected_chars.pop_front();
			if (ch !== e.ch) begin
				errors++;
				$display("%0t: out_char expected %h got %h", $time, e.ch, ch);
			end
			if (last !== e.last) begin
				errors++;
				$display("%0t: last_of_run expected %b got %b (out_char %h)",
					$time, e.last, last, ch);
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

endpackage

[bench/tb_base64_line_wrapping_encoder.sv]
`timescale 1ns / 100ps
// Top of the base64 line-wrapping encoder bench: clock, reset, word driver, character
// monitor with random stalls, and the stimulus phases. Depends on b64lw_pkg, both
// channel interfaces, the encoder RTL and b64lw_tb_pkg.
module tb_base64_line_wrapping_encoder;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	b64lw_in_if  item_ch();
	b64lw_out_if result_ch();

	base64_line_wrapping_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	b64lw_tb_pkg::b64_char_checker board = new();

	bit         quiet = 1'b0;
	logic       hold_request = 1'b0;
	int         hold_left = 0;
	int         stall_left = 0;
	logic [7:0] last_wrap = b64lw_pkg::WRAP_RESET;

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Character monitor and ready driver.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				board.check_char(result_ch.out_char, result_ch.last_of_run);
			if (hold_request) begin
				hold_left = 150;
				hold_request <= 1'b0;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (quiet) begin
				result_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.data_byte <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		board.note_word(cmd, b);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		// let any word that produced nothing clear the pipeline
		repeat (10) @(posedge clk);
	endtask

	task automatic write_wrap(input logic [7:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_wrap(v);
		last_wrap = v;
	endtask

	task automatic send_random(input int count);
		int         r;
		logic [1:0] cmd;
		logic [7:0] b;
		repeat (count) begin
			r = $urandom_range(0, 99);
			b = 8'($urandom_range(0, 255));
			if (r < 72) begin
				cmd = b64lw_pkg::CMD_DATA;
				if ($urandom_range(0, 9) == 0)
					b = b64lw_pkg::NEWLINE_CHAR;
			end else if (r < 84) begin
				cmd = b64lw_pkg::CMD_EOL;
			end else if (r < 93) begin
				cmd = b64lw_pkg::CMD_FINISH;
			end else begin
				cmd = b64lw_tb_pkg::CMD_UNUSED;
			end
			send_word(cmd, b);
		end
	endtask

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.command <= b64lw_pkg::CMD_DATA;
		item_ch.data_byte <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset threshold.
		send_word(b64lw_pkg::CMD_EOL, 8'hA5);         // already at line start: nothing
		send_word(b64lw_pkg::CMD_FINISH, 8'h5A);      // empty finish
		send_word(b64lw_tb_pkg::CMD_UNUSED, 8'hFF);   // ignored
		send_word(b64lw_pkg::CMD_DATA, 8'h00);
		send_word(b64lw_pkg::CMD_DATA, 8'hFF);
		send_word(b64lw_pkg::CMD_DATA, b64lw_pkg::NEWLINE_CHAR);
		send_word(b64lw_pkg::CMD_EOL, 8'h00);         // last byte was a newline: nothing
		send_word(b64lw_pkg::CMD_DATA, 8'h5A);
		send_word(b64lw_pkg::CMD_FINISH, 8'h00);      // two pads
		send_word(b64lw_pkg::CMD_DATA, 8'hFF);
		send_word(b64lw_pkg::CMD_DATA, 8'h00);
		send_word(b64lw_pkg::CMD_FINISH, 8'hFF);      // one pad
		send_word(b64lw_pkg::CMD_DATA, 8'h41);
		send_word(b64lw_pkg::CMD_EOL, 8'hFF);         // encodes a newline byte
		send_word(b64lw_pkg::CMD_EOL, 8'h00);         // redundant
		send_word(b64lw_pkg::CMD_DATA, 8'h81);
		send_word(b64lw_tb_pkg::CMD_UNUSED, 8'h00);
		send_word(b64lw_pkg::CMD_DATA, 8'h7E);
		send_word(b64lw_pkg::CMD_DATA, 8'hC3);
		send_word(b64lw_pkg::CMD_FINISH, 8'h0F);      // one pad
		send_word(b64lw_pkg::CMD_FINISH, 8'h00);

		// Random words; hold the receiver off so the block backs up.
		hold_request <= 1'b1;
		send_random(50);

		// Break after every group, no idling on either side.
		write_wrap(8'd0);
		quiet = 1'b1;
		send_random(30);
		quiet = 1'b0;

		write_wrap(8'd250);
		send_random(50);

		write_wrap(8'($urandom_range(1, 249)));
		send_random(50);

		wait_drained();
		$display("Run covered %0d words and %0d characters (%0d newlines, %0d pads)",
			board.words_noted, board.chars_checked, board.newlines_seen, board.pads_seen);
		$display("over wrap thresholds 70, 0, 250 and %0d, with one long receiver hold",
			last_wrap);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/b64lw_pkg.sv
hw/rtl/b64lw_in_if.sv
hw/rtl/b64lw_out_if.sv
hw/rtl/b64lw_front.sv
hw/rtl/b64lw_queue.sv
hw/rtl/b64lw_back.sv
hw/rtl/base64_line_wrapping_encoder.sv
bench/b64lw_tb_pkg.sv
bench/tb_base64_line_wrapping_encoder.sv
